@@ rtl/ppim0_pkg.sv @@
package ppim0_pkg;

    localparam logic [7:0] MODE_RESET    = 8'h9B;
    localparam logic [7:0] UPPER_NIB     = 8'hF0;
    localparam logic [7:0] LOWER_NIB     = 8'h0F;
    localparam logic [7:0] ALL_ONES      = 8'hFF;
    localparam int unsigned MODE_SET_BIT = 7;

    // mode word direction bits, 1 = input
    localparam int unsigned DIR_A_IN  = 4;
    localparam int unsigned DIR_CU_IN = 3;
    localparam int unsigned DIR_B_IN  = 1;
    localparam int unsigned DIR_CL_IN = 0;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [1:0] SEL_PORT_A  = 2'd0;
    localparam logic [1:0] SEL_PORT_B  = 2'd1;
    localparam logic [1:0] SEL_PORT_C  = 2'd2;
    localparam logic [1:0] SEL_CONTROL = 2'd3;

    localparam logic [2:0] UPD_NONE = 3'b000;
    localparam logic [2:0] UPD_A    = 3'b001;
    localparam logic [2:0] UPD_B    = 3'b010;
    localparam logic [2:0] UPD_C    = 3'b100;
    localparam logic [2:0] UPD_ALL  = 3'b111;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 40;

    typedef struct packed {
        logic       action;
        logic [1:0] reg_select;
        logic [7:0] write_value;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
        logic [7:0] pins_c;
    } access_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [7:0] drive_a;
        logic [7:0] drive_b;
        logic [7:0] drive_c;
        logic [2:0] update_mask;
    } result_t;

endpackage

@@ rtl/parallel_port_interface_mode0_core.sv @@
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: write_value, pins_a, pins_b, pins_c; tuser: action, reg_select
// m_axis    out  tdata: read_value, drive_a, drive_b, drive_c, update_mask, 5 zero bits
//
// One access per clock sustained while m_axis_tready stays high. An accepted
// beat is held in the input register, then the port latches and mode word
// update as its result is loaded into the output register.
// Reset puts the mode word at 0x9B (all ports input) and clears the latches.
// An output stall holds the result and stops the input register; s_axis_tready
// stays high while either stage can still move.
module parallel_port_interface_mode0_core
    import ppim0_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] write_value, [15:8] pins_a, [23:16] pins_b, [31:24] pins_c
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] action, [2:1] reg_select
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] read_value, [15:8] drive_a, [23:16] drive_b, [31:24] drive_c,
    // [34:32] update_mask, [39:35] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic       in_valid_reg;
    access_t    in_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic [7:0] mode_reg, mode_next;
    logic [7:0] latch_a_reg, latch_a_next;
    logic [7:0] latch_b_reg, latch_b_next;
    logic [7:0] latch_c_reg, latch_c_next;
    result_t    res;
    logic       advance;
    logic       a_out, b_out;
    logic [7:0] c_mask, c_mask_next;
    logic [7:0] bit_sel;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign a_out   = !mode_reg[DIR_A_IN];
    assign b_out   = !mode_reg[DIR_B_IN];
    assign c_mask  = (mode_reg[DIR_CU_IN] ? 8'h00 : UPPER_NIB)
                   | (mode_reg[DIR_CL_IN] ? 8'h00 : LOWER_NIB);
    assign bit_sel = 8'(1) << in_reg.write_value[3:1];

    always_comb
    begin
        mode_next       = mode_reg;
        latch_a_next    = latch_a_reg;
        latch_b_next    = latch_b_reg;
        latch_c_next    = latch_c_reg;
        res.read_value  = ALL_ONES;
        res.update_mask = UPD_NONE;
        if (in_reg.action == ACT_WRITE)
        begin
            unique case (in_reg.reg_select)
                SEL_PORT_A:
                begin
                    if (a_out)
                    begin
                        latch_a_next    = in_reg.write_value;
                        res.update_mask = UPD_A;
                    end
                end
                SEL_PORT_B:
                begin
                    if (b_out)
                    begin
                        latch_b_next    = in_reg.write_value;
                        res.update_mask = UPD_B;
                    end
                end
                SEL_PORT_C:
                begin
                    latch_c_next    = in_reg.write_value;
                    res.update_mask = UPD_C;
                end
                SEL_CONTROL:
                begin
                    if (in_reg.write_value[MODE_SET_BIT])
                    begin
                        mode_next       = in_reg.write_value;
                        latch_a_next    = 8'h00;
                        latch_b_next    = 8'h00;
                        latch_c_next    = 8'h00;
                        res.update_mask = UPD_ALL;
                    end
                    else
                    begin
                        // single port C bit set/reset
                        latch_c_next    = in_reg.write_value[0] ? (latch_c_reg | bit_sel)
                                                                : (latch_c_reg & ~bit_sel);
                        res.update_mask = UPD_C;
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (in_reg.reg_select)
                SEL_PORT_A:  res.read_value = a_out ? latch_a_reg : in_reg.pins_a;
                SEL_PORT_B:  res.read_value = b_out ? latch_b_reg : in_reg.pins_b;
                SEL_PORT_C:  res.read_value = (latch_c_reg & c_mask)
                                            | (in_reg.pins_c & ~c_mask);
                SEL_CONTROL: res.read_value = mode_reg;
                default:     res.read_value = ALL_ONES;
            endcase
        end
        // drives reflect the state after this access
        c_mask_next = (mode_next[DIR_CU_IN] ? 8'h00 : UPPER_NIB)
                    | (mode_next[DIR_CL_IN] ? 8'h00 : LOWER_NIB);
        res.drive_a = mode_next[DIR_A_IN] ? ALL_ONES : latch_a_next;
        res.drive_b = mode_next[DIR_B_IN] ? ALL_ONES : latch_b_next;
        res.drive_c = (latch_c_next & c_mask_next) | ~c_mask_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_RESET;
            latch_a_reg   <= 8'h00;
            latch_b_reg   <= 8'h00;
            latch_c_reg   <= 8'h00;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                latch_a_reg   <= latch_a_next;
                latch_b_reg   <= latch_b_next;
                latch_c_reg   <= latch_c_next;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.action      <= s_axis_tuser[0];
            in_reg.reg_select  <= s_axis_tuser[2:1];
            in_reg.write_value <= s_axis_tdata[7:0];
            in_reg.pins_a      <= s_axis_tdata[15:8];
            in_reg.pins_b      <= s_axis_tdata[23:16];
            in_reg.pins_c      <= s_axis_tdata[31:24];
        end
        if (advance)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.update_mask, out_reg.drive_c, out_reg.drive_b,
                            out_reg.drive_a, out_reg.read_value};

endmodule

@@ dv/parallel_port_interface_mode0_core_test.sv @@
`timescale 1ns / 100ps

module parallel_port_interface_mode0_core_test;
    import ppim0_pkg::*;

    localparam int unsigned RANDOM_ACCESSES = 600;
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES    = 8;

    // Shadow copy of the mode word and port latches; predicts one result per access.
    class port_shadow;
        logic [7:0] mode_word = MODE_RESET;
        logic [7:0] latch_a   = 8'h00;
        logic [7:0] latch_b   = 8'h00;
        logic [7:0] latch_c   = 8'h00;
        result_t    pending_results[$];
        int unsigned mismatches = 0;

        // port C bits that are outputs
        function logic [7:0] c_out_mask();
            return {{4{~mode_word[DIR_CU_IN]}}, {4{~mode_word[DIR_CL_IN]}}};
        endfunction

        function void note_access(access_t acc);
            result_t r;
            logic [7:0] cm;
            r = '0;
            r.read_value  = ALL_ONES;
            r.update_mask = UPD_NONE;
            cm = c_out_mask();
            if (acc.action == ACT_WRITE)
            begin
                case (acc.reg_select)
                    SEL_PORT_A:
                        if (!mode_word[DIR_A_IN])
                        begin
                            latch_a = acc.write_value;
                            r.update_mask = UPD_A;
                        end
                    SEL_PORT_B:
                        if (!mode_word[DIR_B_IN])
                        begin
                            latch_b = acc.write_value;
                            r.update_mask = UPD_B;
                        end
                    SEL_PORT_C:
                    begin
                        latch_c = acc.write_value;
                        r.update_mask = UPD_C;
                    end
                    SEL_CONTROL:
                        if (acc.write_value[MODE_SET_BIT])
                        begin
                            mode_word = acc.write_value;
                            latch_a = 8'h00;
                            latch_b = 8'h00;
                            latch_c = 8'h00;
                            r.update_mask = UPD_ALL;
                        end
                        else
                        begin
                            // bit set/reset: [3:1] picks the C bit, [0] is its value
                            latch_c[acc.write_value[3:1]] = acc.write_value[0];
                            r.update_mask = UPD_C;
                        end
                endcase
            end
            else
            begin
                case (acc.reg_select)
                    SEL_PORT_A:  r.read_value = mode_word[DIR_A_IN] ? acc.pins_a : latch_a;
                    SEL_PORT_B:  r.read_value = mode_word[DIR_B_IN] ? acc.pins_b : latch_b;
                    SEL_PORT_C:  r.read_value = (latch_c & cm) | (acc.pins_c & ~cm);
                    SEL_CONTROL: r.read_value = mode_word;
                endcase
            end
            cm = c_out_mask();
            r.drive_a = mode_word[DIR_A_IN] ? ALL_ONES : latch_a;
            r.drive_b = mode_word[DIR_B_IN] ? ALL_ONES : latch_b;
            r.drive_c = (latch_c & cm) | ~cm;
            pending_results.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            result_t want;
            if (pending_results.size() == 0)
            begin
                flag($sformatf("result beat %010h with nothing expected", beat));
                return;
            end
            want = pending_results.pop_front();
            if (beat[7:0] !== want.read_value)
                flag($sformatf("read_value expected %02h got %02h", want.read_value, beat[7:0]));
            if (beat[15:8] !== want.drive_a)
                flag($sformatf("drive_a expected %02h got %02h", want.drive_a, beat[15:8]));
            if (beat[23:16] !== want.drive_b)
                flag($sformatf("drive_b expected %02h got %02h", want.drive_b, beat[23:16]));
            if (beat[31:24] !== want.drive_c)
                flag($sformatf("drive_c expected %02h got %02h", want.drive_c, beat[31:24]));
            if (beat[34:32] !== want.update_mask)
                flag($sformatf("update_mask expected %0d got %0d", want.update_mask,
                               beat[34:32]));
            if (beat[39:35] !== 5'b0)
                flag($sformatf("pad bits expected 0 got %02h", beat[39:35]));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // write_value, pins_a, pins_b, pins_c
    logic [S_TUSER_W-1:0] s_axis_tuser;   // action, reg_select
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // read_value, drive_a, drive_b, drive_c, update_mask

    port_shadow  board;
    bit          tx_no_gaps;
    bit          rx_no_stalls;
    int unsigned rx_hold;
    int unsigned idle_cycles;

    parallel_port_interface_mode0_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Handshakes are judged on the values seen at the edge, before any update lands.
    task automatic send_access(input logic act, input logic [1:0] sel,
                               input logic [7:0] wv, input logic [7:0] pa,
                               input logic [7:0] pb, input logic [7:0] pc);
        int unsigned gap;
        access_t acc;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pc, pb, pa, wv};
        s_axis_tuser  <= {sel, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        acc.action      = act;
        acc.reg_select  = sel;
        acc.write_value = wv;
        acc.pins_a      = pa;
        acc.pins_b      = pb;
        acc.pins_c      = pc;
        board.note_access(acc);
    endtask

    task automatic send_random_access();
        logic       act;
        logic [1:0] sel;
        logic [7:0] wv;
        act = 1'($urandom_range(0, 1));
        sel = 2'($urandom_range(0, 3));
        wv  = 8'($urandom_range(0, 255));
        // keep mode word writes rarer than bit set/reset so latches can build up
        if (act == ACT_WRITE && sel == SEL_CONTROL)
            wv[MODE_SET_BIT] = ($urandom_range(0, 3) == 0);
        send_access(act, sel, wv, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                board.check_result(m_axis_tdata);
                rx_hold = rx_no_stalls ? 0 : $urandom_range(0, 4);
            end
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned i;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        tx_no_gaps    = 1'b0;
        rx_no_stalls  = 1'b0;
        rx_hold       = 0;
        idle_cycles   = 0;
        board = new;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // after reset every port is an input: reads return the pins
        send_access(ACT_READ,  SEL_PORT_A,  8'h00, 8'hFF, 8'h00, 8'h00);
        send_access(ACT_READ,  SEL_PORT_B,  8'hFF, 8'hFF, 8'h00, 8'hFF);
        send_access(ACT_READ,  SEL_PORT_C,  8'h00, 8'h00, 8'hFF, 8'h5A);
        send_access(ACT_READ,  SEL_CONTROL, 8'h00, 8'h00, 8'h00, 8'h00);
        // writes to input A/B are dropped, C always latches
        send_access(ACT_WRITE, SEL_PORT_A,  8'h55, 8'h00, 8'h00, 8'h00);
        send_access(ACT_WRITE, SEL_PORT_B,  8'hAA, 8'h00, 8'h00, 8'h00);
        send_access(ACT_WRITE, SEL_PORT_C,  8'h3C, 8'h00, 8'h00, 8'h00);
        // all outputs, latches cleared
        send_access(ACT_WRITE, SEL_CONTROL, 8'h80, 8'h00, 8'h00, 8'h00);
        send_access(ACT_WRITE, SEL_PORT_A,  8'hFF, 8'h00, 8'h00, 8'h00);
        send_access(ACT_WRITE, SEL_PORT_B,  8'hFF, 8'h00, 8'h00, 8'h00);
        send_access(ACT_WRITE, SEL_PORT_C,  8'hFF, 8'h00, 8'h00, 8'h00);
        send_access(ACT_READ,  SEL_PORT_A,  8'h00, 8'h00, 8'hFF, 8'hFF);
        send_access(ACT_READ,  SEL_PORT_B,  8'h00, 8'hFF, 8'h00, 8'hFF);
        send_access(ACT_READ,  SEL_PORT_C,  8'h00, 8'hFF, 8'hFF, 8'h00);
        // bit set/reset on C, top and bottom bit
        send_access(ACT_WRITE, SEL_CONTROL, 8'h0E, 8'h00, 8'h00, 8'h00);
        send_access(ACT_WRITE, SEL_CONTROL, 8'h00, 8'h00, 8'h00, 8'h00);
        send_access(ACT_WRITE, SEL_CONTROL, 8'h01, 8'h00, 8'h00, 8'h00);
        // split C: upper nibble input, lower output
        send_access(ACT_WRITE, SEL_CONTROL, 8'h88, 8'h00, 8'h00, 8'h00);
        send_access(ACT_WRITE, SEL_CONTROL, 8'h0F, 8'h00, 8'h00, 8'h00);
        send_access(ACT_READ,  SEL_PORT_C,  8'h00, 8'h00, 8'h00, 8'hA5);
        // split C the other way
        send_access(ACT_WRITE, SEL_CONTROL, 8'h81, 8'h00, 8'h00, 8'h00);
        send_access(ACT_READ,  SEL_PORT_C,  8'h00, 8'h00, 8'h00, 8'h5A);
        // all inputs with every spare bit set
        send_access(ACT_WRITE, SEL_CONTROL, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_access(ACT_READ,  SEL_CONTROL, 8'h00, 8'h00, 8'h00, 8'h00);

        for (i = 0; i < RANDOM_ACCESSES; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_no_gaps   = ($urandom_range(0, 3) == 0);
                rx_no_stalls = ($urandom_range(0, 3) == 0);
            end
            send_random_access();
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
